[sv/b64enc_pkg.sv]
// Package for the base64 stream encoder: payload structs, the internal
// command type passed from the front end to the back end, and the alphabet.
// No dependencies.
package b64enc_pkg;

  localparam int unsigned CMDQ_DEPTH_DEF = 2;
  localparam logic [7:0]  PAD_CHAR       = 8'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } out_item_t;

  // One input byte turned into a list of characters: one or two alphabet
  // indices followed by zero to two pad characters.
  typedef struct packed {
    logic [5:0] idx0;
    logic [5:0] idx1;
    logic       two_data;
    logic [1:0] n_pad;
  } cmd_t;

  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] c;
    if (idx < 6'd26) begin
      c = 8'h41 + {2'b00, idx};
    end else if (idx < 6'd52) begin
      c = 8'h61 + {2'b00, idx - 6'd26};
    end else if (idx < 6'd62) begin
      c = 8'h30 + {2'b00, idx - 6'd52};
    end else if (idx == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

[sv/b64enc_front.sv]
// Front end of the base64 encoder: merges each byte with the pending bits
// and builds a character command for the queue. Depends on b64enc_pkg.
module b64enc_front
  import b64enc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_data,
  input  logic     push,
  output cmd_t     cmd
);

  typedef enum logic [1:0] {
    PEND_0,
    PEND_2,
    PEND_4
  } pend_t;

  pend_t      pend_r, pend_nxt;
  logic [3:0] acc_r, acc_nxt;
  logic [1:0] cmf_r, cmf_nxt;

  logic [5:0] idx0, idx1_full, idx_flush;
  logic       two_full;
  pend_t      pend_step;
  logic [3:0] rem;
  logic [1:0] cnt_after;
  logic [7:0] b;
  logic       last;

  assign b    = in_data.data_byte;
  assign last = in_data.last_byte;

  always_comb begin
    idx0      = b[7:2];
    idx1_full = 6'd0;
    idx_flush = {b[1:0], 4'b0000};
    two_full  = 1'b0;
    rem       = {2'b00, b[1:0]};
    pend_step = PEND_2;
    case (pend_r)
      PEND_0: begin
        idx0      = b[7:2];
        idx_flush = {b[1:0], 4'b0000};
        rem       = {2'b00, b[1:0]};
        pend_step = PEND_2;
      end
      PEND_2: begin
        idx0      = {acc_r[1:0], b[7:4]};
        idx_flush = {b[3:0], 2'b00};
        rem       = b[3:0];
        pend_step = PEND_4;
      end
      PEND_4: begin
        idx0      = {acc_r[3:0], b[7:6]};
        idx1_full = b[5:0];
        two_full  = 1'b1;
        rem       = 4'd0;
        pend_step = PEND_0;
      end
      default: begin
        idx0      = b[7:2];
        idx_flush = {b[1:0], 4'b0000};
        rem       = {2'b00, b[1:0]};
        pend_step = PEND_2;
      end
    endcase
  end

  // On the last byte the leftover bits always form a second character,
  // unless the byte already completed two full groups.
  always_comb begin
    cmd.idx0     = idx0;
    cmd.idx1     = two_full ? idx1_full : idx_flush;
    cmd.two_data = two_full | last;
    cnt_after    = cmf_r + (cmd.two_data ? 2'd2 : 2'd1);
    cmd.n_pad    = last ? (2'd0 - cnt_after) : 2'd0;
  end

  always_comb begin
    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    cmf_nxt  = cmf_r;
    if (push && in_valid) begin
      if (last) begin
        pend_nxt = PEND_0;
        acc_nxt  = 4'd0;
        cmf_nxt  = 2'd0;
      end else begin
        pend_nxt = pend_step;
        acc_nxt  = rem;
        cmf_nxt  = cnt_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PEND_0;
      acc_r  <= 4'd0;
      cmf_r  <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
      cmf_r  <= cmf_nxt;
    end
  end

endmodule

[sv/b64enc_cmdq.sv]
// Small command queue between the encoder front and back ends, built from
// flip-flops. Depends on b64enc_pkg.
module b64enc_cmdq
  import b64enc_pkg::*;
#(
  parameter int unsigned DEPTH = CMDQ_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t            mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[sv/b64enc_back.sv]
// Back end of the base64 encoder: moves the head command into the output
// register, one character per cycle when it can load. Depends on b64enc_pkg.
module b64enc_back
  import b64enc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  cmd_t      head_cmd,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [2:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic       load;
  logic [2:0] last_k;
  logic [7:0] ch;

  assign last_k = 3'(head_cmd.two_data) + 3'(head_cmd.n_pad);
  assign load   = head_valid && (!out_valid_r || out_ready);
  assign pop    = load && (k_r == last_k);

  always_comb begin
    if (k_r == 3'd0) begin
      ch = b64_char(head_cmd.idx0);
    end else if (k_r == 3'd1 && head_cmd.two_data) begin
      ch = b64_char(head_cmd.idx1);
    end else begin
      ch = PAD_CHAR;
    end
  end

  always_comb begin
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.character = ch;
      out_data_nxt.last_char = (k_r == last_k);
      k_nxt                  = (k_r == last_k) ? 3'd0 : k_r + 3'd1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/base64_stream_encoder_core.sv]
// Base64 stream encoder (standard alphabet, '=' padding). A byte is taken in
// any cycle in which the command queue has room, so bytes enter back to back
// while earlier characters drain; each byte becomes one to four characters,
// sent one per cycle from a registered output while out_ready is high. The
// output port sets the sustained rate: one transfer per character, 4/3
// characters per byte on average over a long stream. A byte's first character
// goes through the command queue and then the output register.
module base64_stream_encoder_core
  import b64enc_pkg::*;
#(
  parameter int unsigned CMDQ_DEPTH = CMDQ_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t cmd, head_cmd;
  logic q_full, q_push, q_pop, head_valid;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  b64enc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_data (in_data),
    .push    (q_push),
    .cmd     (cmd)
  );

  b64enc_cmdq #(
    .DEPTH(CMDQ_DEPTH)
  ) u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  b64enc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[sv/b64enc_checker.sv]
// Port-level checks for the base64 encoder, bound to the top level.
// Depends on b64enc_pkg and base64_stream_encoder_core.
module b64enc_checker
  import b64enc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic       out_fire;
  logic       is_pad;
  logic       pad_seen_r;
  logic [1:0] char_cnt_r;

  assign out_fire = out_valid && out_ready;
  assign is_pad   = (out_data.character == PAD_CHAR);

  // Pad characters close a stream; the count of characters is kept modulo 4.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_seen_r <= 1'b0;
      char_cnt_r <= 2'd0;
    end else if (out_fire) begin
      char_cnt_r <= char_cnt_r + 2'd1;
      if (is_pad && !out_data.last_char) begin
        pad_seen_r <= 1'b1;
      end else if (out_data.last_char) begin
        pad_seen_r <= 1'b0;
      end
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_pad_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && pad_seen_r |-> is_pad)
    else $error("data character after padding");

  a_pad_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && is_pad && out_data.last_char |-> char_cnt_r == 2'd3)
    else $error("padded stream not a multiple of four characters");

endmodule

bind base64_stream_encoder_core b64enc_checker u_b64enc_checker (.*);

[tb/sv/b64enc_scoreboard.sv]
// Scoreboard for the base64 stream encoder: watches both channels, predicts
// the characters of every accepted byte and compares them in order.
// Depends on b64enc_pkg for the payload types and the pad character.
module b64enc_scoreboard
  import b64enc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  output int unsigned mismatch_count,
  output int unsigned chars_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [13:0] bit_acc;
  logic [3:0]  bits_held;
  logic [1:0]  char_phase;
  out_item_t   expected_chars[$];
  out_item_t   oldest;
  int unsigned errs;

  initial begin
    errs = 0;
  end

  function automatic logic [7:0] b64_symbol(input logic [5:0] idx);
    return B64_ALPHABET[8*(63-int'(idx)) +: 8];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errs++;
  endtask

  // Appends the characters that one input byte produces to the expected list.
  task automatic encode_byte(input in_item_t item);
    logic [13:0] acc;
    int          nbits;
    logic [7:0]  chars[$];
    out_item_t   one;
    nbits = (bits_held > 4'd4) ? 4 : int'(bits_held);
    acc = bit_acc & ((14'd1 << nbits) - 14'd1);
    acc = (acc << 8) | {6'd0, item.data_byte};
    nbits += 8;
    while (nbits >= 6) begin
      chars.push_back(b64_symbol(6'((acc >> (nbits - 6)) & 14'h3F)));
      char_phase++;
      nbits -= 6;
      acc &= (14'd1 << nbits) - 14'd1;
    end
    if (item.last_byte) begin
      if (nbits != 0) begin
        // Leftover bits go out left-aligned with zero fill.
        chars.push_back(b64_symbol(6'((acc << (6 - nbits)) & 14'h3F)));
        char_phase++;
      end
      while (char_phase != 2'd0 && chars.size() < 5) begin
        chars.push_back(PAD_CHAR);
        char_phase++;
      end
      acc        = '0;
      nbits      = 0;
      char_phase = '0;
    end
    bit_acc   = acc;
    bits_held = 4'(nbits);
    foreach (chars[i]) begin
      one.character = chars[i];
      one.last_char = (i == chars.size() - 1);
      expected_chars.push_back(one);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      bit_acc    = '0;
      bits_held  = '0;
      char_phase = '0;
      expected_chars.delete();
    end else begin
      if (in_valid && in_ready) begin
        encode_byte(in_data);
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h with nothing expected",
                                    out_data.character));
        end else begin
          oldest = expected_chars.pop_front();
          if (out_data.character !== oldest.character) begin
            report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                      out_data.character, oldest.character));
          end
          if (out_data.last_char !== oldest.last_char) begin
            report_mismatch($sformatf("last_char %0b, expected %0b on 0x%02h",
                                      out_data.last_char, oldest.last_char,
                                      oldest.character));
          end
        end
      end
    end
    mismatch_count <= errs;
    chars_pending  <= expected_chars.size();
  end

endmodule

[tb/sv/tb_base64_stream_encoder_core.sv]
// Top testbench for base64_stream_encoder_core: clock, reset, byte streams
// and output back-pressure, with the verdict taken from b64enc_scoreboard.
// Depends on b64enc_pkg, the encoder core and the scoreboard.
module tb_base64_stream_encoder_core;
  import b64enc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 250;

  // Short streams that hit both all-zero and all-one groups, '+' and '/',
  // and every stream length modulo three.
  localparam logic [8:0] DIRECTED_BYTES[16] = '{
    {8'h00, 1'b1},
    {8'hFF, 1'b1},
    {8'hFB, 1'b0}, {8'hEF, 1'b1},
    {8'hFB, 1'b0}, {8'hFF, 1'b0}, {8'hBF, 1'b1},
    {8'h4D, 1'b0}, {8'h61, 1'b0}, {8'h6E, 1'b0}, {8'h00, 1'b1},
    {8'h55, 1'b0}, {8'hAA, 1'b0}, {8'h0F, 1'b0}, {8'hF0, 1'b0}, {8'h80, 1'b1}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  int unsigned mismatch_count;
  int unsigned chars_pending;
  int unsigned bytes_sent;
  bit          in_calm;
  bit          out_calm;

  base64_stream_encoder_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  b64enc_scoreboard i_scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatch_count(mismatch_count),
    .chars_pending (chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Holds valid from the first cycle of a transaction until it is accepted.
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= in_item_t'{data_byte: value, last_byte: is_last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  initial begin
    int len;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    bytes_sent = 0;
    in_calm    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED_BYTES[i]) begin
      send_byte(DIRECTED_BYTES[i][8:1], DIRECTED_BYTES[i][0]);
    end
    while (bytes_sent < RANDOM_BYTES + 16) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      in_calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        send_byte(8'($urandom_range(0, 255)), k == len - 1);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Output back-pressure: a fresh stall for every transaction, with calm
  // stretches in which ready stays high.
  initial begin
    int stall;
    out_ready <= 1'b0;
    out_calm  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = ~out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

endmodule

[files.f]
sv/b64enc_pkg.sv
sv/b64enc_front.sv
sv/b64enc_cmdq.sv
sv/b64enc_back.sv
sv/base64_stream_encoder_core.sv
sv/b64enc_checker.sv
tb/sv/b64enc_scoreboard.sv
tb/sv/tb_base64_stream_encoder_core.sv
